// ===== sv/sfcp_pkg.sv =====
// Shared types, constants and microcode table of the serial flash command planner.
package sfcp_pkg;

    // Flash geometry and request limits (powers of two)
    localparam int unsigned PAGE_BYTES        = 256;
    localparam int unsigned SECTOR_BYTES      = 4096;
    localparam int unsigned BLOCK_BYTES       = 65536;
    localparam int unsigned MAX_REQUEST_BYTES = 4096;

    localparam int unsigned PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int unsigned BLOCK_SHIFT  = $clog2(BLOCK_BYTES);

    localparam int unsigned CFG_W        = 11;
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned COUNT_W      = 13;
    localparam int unsigned WAIT_W       = 20;
    localparam int unsigned RESULT_LIMIT = 17;
    localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT + 1);

    localparam logic [CFG_W-1:0] BLOCK_COUNT_MAX = CFG_W'(1024);
    localparam logic [CFG_W-1:0] WIDE_THRESHOLD  = CFG_W'(512);

    // Command bytes
    localparam logic [7:0] OPC_WRITE3  = 8'h02;
    localparam logic [7:0] OPC_WRITE4  = 8'h12;
    localparam logic [7:0] OPC_READ3   = 8'h03;
    localparam logic [7:0] OPC_READ4   = 8'h13;
    localparam logic [7:0] OPC_SECTOR3 = 8'h20;
    localparam logic [7:0] OPC_SECTOR4 = 8'h21;
    localparam logic [7:0] OPC_BLOCK3  = 8'hD8;
    localparam logic [7:0] OPC_BLOCK4  = 8'hDC;
    localparam logic [7:0] OPC_CHIP    = 8'h60;

    // Busy-poll limits in milliseconds
    localparam logic [WAIT_W-1:0] WAIT_PAGE     = WAIT_W'(100);
    localparam logic [WAIT_W-1:0] WAIT_SECTOR   = WAIT_W'(1000);
    localparam logic [WAIT_W-1:0] WAIT_BLOCK    = WAIT_W'(3000);
    localparam logic [WAIT_W-1:0] WAIT_PER_BLOCK = WAIT_W'(1000);

    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_SECTOR = 3'd2,
        REQ_BLOCK  = 3'd3,
        REQ_CHIP   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PAGE   = 2'd1,
        ST_SECTOR = 2'd2,
        ST_BLOCK  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_FETCH, OP_READ, OP_WRITE, OP_SECTOR, OP_BLOCK, OP_CHIP
    } t_op;

    typedef enum logic [1:0] {
        JC_ALWAYS, JC_MORE, JC_DISPATCH
    } t_cond;

    typedef enum logic [2:0] {
        UA_FETCH, UA_READ, UA_WRITE, UA_SECTOR, UA_BLOCK, UA_CHIP
    } t_uaddr;

    typedef struct packed {
        t_op    op;
        t_cond  cond;
        t_uaddr tgt;
    } t_uword;

    typedef struct packed {
        t_status             status;
        logic [7:0]          opcode;
        logic [ADDR_W-1:0]   flash_address;
        logic [2:0]          address_bytes;
        logic [COUNT_W-1:0]  data_offset;
        logic [COUNT_W-1:0]  data_count;
        logic                needs_write_enable;
        logic [WAIT_W-1:0]   wait_limit_ms;
        logic                last;
    } t_desc;

    typedef struct packed {
        logic load;
        logic step;
        t_op  op;
    } t_dp_ctrl;

    typedef struct packed {
        t_desc desc;
        logic  more;
    } t_dp_stat;

    // Control store: one word per microcode address.
    function automatic t_uword micro_rom(input t_uaddr a);
        t_uword w;
        unique case (a)
            UA_FETCH:  w = '{op: OP_FETCH,  cond: JC_DISPATCH, tgt: UA_FETCH};
            UA_READ:   w = '{op: OP_READ,   cond: JC_ALWAYS,   tgt: UA_FETCH};
            UA_WRITE:  w = '{op: OP_WRITE,  cond: JC_MORE,     tgt: UA_WRITE};
            UA_SECTOR: w = '{op: OP_SECTOR, cond: JC_ALWAYS,   tgt: UA_FETCH};
            UA_BLOCK:  w = '{op: OP_BLOCK,  cond: JC_ALWAYS,   tgt: UA_FETCH};
            UA_CHIP:   w = '{op: OP_CHIP,   cond: JC_ALWAYS,   tgt: UA_FETCH};
            default:   w = '{op: OP_FETCH,  cond: JC_ALWAYS,   tgt: UA_FETCH};
        endcase
        return w;
    endfunction

    // Entry point of the routine for a request type; unknown types stay at fetch.
    function automatic t_uaddr dispatch(input logic [2:0] req);
        t_uaddr a;
        unique case (t_req'(req))
            REQ_READ:   a = UA_READ;
            REQ_WRITE:  a = UA_WRITE;
            REQ_SECTOR: a = UA_SECTOR;
            REQ_BLOCK:  a = UA_BLOCK;
            REQ_CHIP:   a = UA_CHIP;
            default:    a = UA_FETCH;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/sfcp_req_if.sv =====
// Request channel: one flash request per item.
interface sfcp_req_if;
    import sfcp_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic [ADDR_W-1:0]   target;
    logic [COUNT_W-1:0]  byte_count;

    modport source(output valid, req_type, target, byte_count, input ready);
    modport sink(input valid, req_type, target, byte_count, output ready);
endinterface

// ===== sv/sfcp_desc_if.sv =====
// Descriptor channel: one command descriptor per item.
interface sfcp_desc_if;
    import sfcp_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [7:0]          opcode;
    logic [ADDR_W-1:0]   flash_address;
    logic [2:0]          address_bytes;
    logic [COUNT_W-1:0]  data_offset;
    logic [COUNT_W-1:0]  data_count;
    logic                needs_write_enable;
    logic [WAIT_W-1:0]   wait_limit_ms;
    logic                last;

    modport source(output valid, status, opcode, flash_address, address_bytes, data_offset,
                   data_count, needs_write_enable, wait_limit_ms, last, input ready);
    modport sink(input valid, status, opcode, flash_address, address_bytes, data_offset,
                 data_count, needs_write_enable, wait_limit_ms, last, output ready);
endinterface

// ===== sv/sfcp_dpath.sv =====
// Datapath: chip size register, write walk state and descriptor formation.
module sfcp_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [sfcp_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  sfcp_pkg::t_dp_ctrl           i_ctrl,
    input  logic [sfcp_pkg::ADDR_W-1:0]  i_target,
    input  logic [sfcp_pkg::COUNT_W-1:0] i_byte_count,
    output sfcp_pkg::t_dp_stat           o_stat
);
    import sfcp_pkg::*;

    logic [CFG_W-1:0]   r_block_count;
    logic [WAIT_W-1:0]  r_chip_wait;
    logic [ADDR_W-1:0]  r_addr;
    logic [COUNT_W-1:0] r_bytes_left;
    logic [COUNT_W-1:0] r_buf_idx;
    logic [CNT_W-1:0]   r_count;

    logic [CFG_W-1:0]   cfg_clamped;
    logic [COUNT_W-1:0] req_clamped;
    logic               wide;
    logic [ADDR_W-1:0]  amask;
    logic [2:0]         abytes;
    logic               page_err;
    logic               sector_err;
    logic               block_err;
    logic [COUNT_W-1:0] room;
    logic [COUNT_W-1:0] len;
    logic [COUNT_W-1:0] left_next;
    logic               fin;
    logic               write_step;
    t_desc              desc;

    assign cfg_clamped = (i_cfg_wr_data > BLOCK_COUNT_MAX) ? BLOCK_COUNT_MAX : i_cfg_wr_data;
    assign req_clamped = (i_byte_count > COUNT_W'(MAX_REQUEST_BYTES))
                       ? COUNT_W'(MAX_REQUEST_BYTES) : i_byte_count;

    assign wide   = (r_block_count >= WIDE_THRESHOLD);
    assign amask  = wide ? {ADDR_W{1'b1}} : ADDR_W'(32'h00FF_FFFF);
    assign abytes = wide ? 3'd4 : 3'd3;

    // An address lies beyond the chip exactly when its block index does.
    assign page_err   = (r_addr >> BLOCK_SHIFT) >= ADDR_W'(r_block_count);
    assign sector_err = r_addr >= (ADDR_W'(r_block_count) << (BLOCK_SHIFT - SECTOR_SHIFT));
    assign block_err  = r_addr >= ADDR_W'(r_block_count);

    assign room      = COUNT_W'(PAGE_BYTES) - COUNT_W'(r_addr[PAGE_SHIFT-1:0]);
    assign len       = (r_bytes_left < room) ? r_bytes_left : room;
    assign left_next = r_bytes_left - len;
    assign fin       = (left_next == '0) || (r_count == CNT_W'(RESULT_LIMIT - 1));

    always_comb begin
        desc = '0;
        case (i_ctrl.op)
            OP_READ: begin
                desc.opcode        = wide ? OPC_READ4 : OPC_READ3;
                desc.flash_address = r_addr & amask;
                desc.address_bytes = abytes;
                desc.data_count    = r_bytes_left;
                desc.last          = 1'b1;
            end
            OP_WRITE: begin
                if (page_err) begin
                    desc.status = ST_PAGE;
                    desc.last   = 1'b1;
                end else begin
                    desc.opcode             = wide ? OPC_WRITE4 : OPC_WRITE3;
                    desc.flash_address      = r_addr & amask;
                    desc.address_bytes      = abytes;
                    desc.data_offset        = r_buf_idx;
                    desc.data_count         = len;
                    desc.needs_write_enable = 1'b1;
                    desc.wait_limit_ms      = WAIT_PAGE;
                    desc.last               = fin;
                end
            end
            OP_SECTOR: begin
                if (sector_err) begin
                    desc.status = ST_SECTOR;
                    desc.last   = 1'b1;
                end else begin
                    desc.opcode             = wide ? OPC_SECTOR4 : OPC_SECTOR3;
                    desc.flash_address      = (r_addr << SECTOR_SHIFT) & amask;
                    desc.address_bytes      = abytes;
                    desc.needs_write_enable = 1'b1;
                    desc.wait_limit_ms      = WAIT_SECTOR;
                    desc.last               = 1'b1;
                end
            end
            OP_BLOCK: begin
                if (block_err) begin
                    desc.status = ST_BLOCK;
                    desc.last   = 1'b1;
                end else begin
                    desc.opcode             = wide ? OPC_BLOCK4 : OPC_BLOCK3;
                    desc.flash_address      = (r_addr << BLOCK_SHIFT) & amask;
                    desc.address_bytes      = abytes;
                    desc.needs_write_enable = 1'b1;
                    desc.wait_limit_ms      = WAIT_BLOCK;
                    desc.last               = 1'b1;
                end
            end
            OP_CHIP: begin
                desc.opcode             = OPC_CHIP;
                desc.needs_write_enable = 1'b1;
                desc.wait_limit_ms      = r_chip_wait;
                desc.last               = 1'b1;
            end
            default: begin
                desc = '0;
            end
        endcase
    end

    assign write_step  = i_ctrl.step && (i_ctrl.op == OP_WRITE) && !page_err;
    assign o_stat.desc = desc;
    assign o_stat.more = (i_ctrl.op == OP_WRITE) && !page_err && !fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
            r_chip_wait   <= '0;
            r_addr        <= '0;
            r_bytes_left  <= '0;
            r_buf_idx     <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_block_count <= cfg_clamped;
                r_chip_wait   <= WAIT_W'(WAIT_W'(cfg_clamped) * WAIT_PER_BLOCK);
            end
            if (i_ctrl.load) begin
                r_addr       <= i_target;
                r_bytes_left <= req_clamped;
                r_buf_idx    <= '0;
                r_count      <= '0;
            end else if (write_step) begin
                r_addr       <= r_addr + ADDR_W'(len);
                r_bytes_left <= left_next;
                r_buf_idx    <= r_buf_idx + len;
                r_count      <= r_count + CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RESULT_LIMIT))
        else $error("frame counter passed the descriptor limit");

    a_page_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (write_step && !fin) |=> (r_addr[PAGE_SHIFT-1:0] == '0))
        else $error("write walk continued from a non page-aligned address");

    a_bytes_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_buf_idx} + {1'b0, r_bytes_left}) <= (COUNT_W + 1)'(MAX_REQUEST_BYTES))
        else $error("buffer index and remaining bytes exceed the request size");

endmodule

// ===== sv/serial_flash_command_planner.sv =====
// Top level of the serial flash command planner: microcode sequencer and descriptor register.
//
//  Channel   Direction  Handshake      Carries
//  i_req     in         valid/ready    req_type, target, byte_count
//  o_desc    out        valid/ready    status, opcode, address, data slice, WE, wait, last
//  i_cfg_*   in         write enable   block_count (11 bits, clamped to 1024)
//
// An item is taken at the fetch step; each descriptor then takes one step of the sequencer,
// and a request yields at most 17 descriptors. The write routine's single self-looping
// microcode step sets the rate: one page per cycle while the output slot is free.
// Reset is synchronous and active low; it clears the microcode address, the output valid,
// the block count and the write walk state.
// A stalled descriptor holds the sequencer at its current step; the next descriptor is
// formed in the cycle the held one is taken.
module serial_flash_command_planner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [sfcp_pkg::CFG_W-1:0] i_cfg_wr_data,
    sfcp_req_if.sink                   i_req,
    sfcp_desc_if.source                o_desc
);
    import sfcp_pkg::*;

    // Microcode address and the control word it selects.
    t_uaddr   r_pc;
    t_uaddr   n_pc;
    t_uword   uword;

    // Output register that parts the sequencer from the descriptor sink.
    logic     r_out_valid;
    t_desc    r_out;

    logic     slot_free;
    logic     step;
    t_dp_ctrl ctrl;
    t_dp_stat dstat;

    assign uword     = micro_rom(r_pc);
    assign slot_free = !r_out_valid || o_desc.ready;

    // The fetch step waits for a request; every other step waits for a free output slot.
    assign step = (uword.op == OP_FETCH) ? i_req.valid : slot_free;

    assign i_req.ready = (uword.op == OP_FETCH);

    assign ctrl.load = step && (uword.op == OP_FETCH);
    assign ctrl.step = step && (uword.op != OP_FETCH);
    assign ctrl.op   = uword.op;

    // Next-address logic: dispatch on request type, loop while pages remain, or jump.
    always_comb begin
        n_pc = r_pc;
        if (step) begin
            unique case (uword.cond)
                JC_DISPATCH: n_pc = dispatch(i_req.req_type);
                JC_MORE:     n_pc = dstat.more ? uword.tgt : UA_FETCH;
                JC_ALWAYS:   n_pc = uword.tgt;
                default:     n_pc = UA_FETCH;
            endcase
        end
    end

    sfcp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctrl        (ctrl),
        .i_target      (i_req.target),
        .i_byte_count  (i_req.byte_count),
        .o_stat        (dstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UA_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (ctrl.step) begin
                r_out_valid <= 1'b1;
                r_out       <= dstat.desc;
            end else if (o_desc.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_desc.valid              = r_out_valid;
    assign o_desc.status             = r_out.status;
    assign o_desc.opcode             = r_out.opcode;
    assign o_desc.flash_address      = r_out.flash_address;
    assign o_desc.address_bytes      = r_out.address_bytes;
    assign o_desc.data_offset        = r_out.data_offset;
    assign o_desc.data_count         = r_out.data_count;
    assign o_desc.needs_write_enable = r_out.needs_write_enable;
    assign o_desc.wait_limit_ms      = r_out.wait_limit_ms;
    assign o_desc.last               = r_out.last;

    a_error_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_desc.valid && (o_desc.status != ST_OK)) |-> o_desc.last)
        else $error("error descriptor without last");

    a_last_returns_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.step && dstat.desc.last) |=> (r_pc == UA_FETCH))
        else $error("sequencer did not return to fetch after the final descriptor");

    a_write_within_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_desc.valid && ((o_desc.opcode == OPC_WRITE3) || (o_desc.opcode == OPC_WRITE4)))
        |-> (o_desc.data_count <= COUNT_W'(PAGE_BYTES)))
        else $error("write frame longer than a page");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the serial flash command planner.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcp_pkg::*;

    // Request codes the block does not know; it takes such an item and sends nothing back.
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Each side holds off in about this percentage of cycles.
    localparam int IDLE_PERCENT = 17;
    // Longest hold-off of the sender and longest stall of the receiver, in cycles.
    localparam int MAX_GAP   = 10;
    localparam int MAX_STALL = 8;
    // A request takes the fetch step plus one sequencer step per descriptor before the block
    // is idle again. The settle pause gives it a little room beyond that.
    localparam int SETTLE_CYCLES = 20;
    // The longest correct stretch with nothing accepted on either channel is a settle
    // pause, a register write and a full sender gap; a receiver stall is shorter
    // still. The limit lies far above that stretch.
    localparam int WATCHDOG_LIMIT = 1000;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 52;
    // In this phase the sender stops halfway and lets every outstanding descriptor drain.
    localparam int PRESSURE_PHASE  = 2;
    // In this phase neither side idles at all.
    localparam int CALM_PHASE      = 4;
    localparam int REPORT_LIMIT    = 20;

    // One line of the directed stimulus: either a block_count write or a request. Where
    // the answer is obvious it is typed in and checked as it stands; otherwise the
    // descriptor planner below works it out.
    typedef struct {
        bit                 is_cfg;
        logic [CFG_W-1:0]   blocks;
        logic [2:0]         kind;
        logic [ADDR_W-1:0]  target;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        t_desc              known;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    sfcp_req_if  req_bus();
    sfcp_desc_if desc_bus();

    serial_flash_command_planner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_bus),
        .o_desc        (desc_bus)
    );

    // Our own view of the block: the chip size as last written, and the page walk of
    // the write in progress. Both start cleared, as the block does after reset.
    logic [CFG_W-1:0]   flash_blocks = '0;
    logic [ADDR_W-1:0]  walk_addr    = '0;
    logic [COUNT_W-1:0] walk_left    = '0;
    logic [COUNT_W-1:0] walk_index   = '0;

    // Descriptors the block still owes us, oldest first.
    t_desc planned_descs [$];
    t_row  directed_plan [$];

    bit calm = 1'b0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int descs_checked = 0;
    int range_errors = 0;
    int reqs_sent = 0;
    int reqs_ignored = 0;
    int settings_written = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Small helpers for building descriptors and stimulus lines
    // ---------------------------------------------------------------------------------

    // A single-descriptor answer: no buffer offset, and it closes the request.
    function automatic t_desc reply(input t_status st, input logic [7:0] op,
                                    input logic [ADDR_W-1:0] addr, input logic [2:0] abytes,
                                    input logic [COUNT_W-1:0] cnt, input logic we,
                                    input logic [WAIT_W-1:0] ms);
        t_desc d;
        d = '0;
        d.status             = st;
        d.opcode             = op;
        d.flash_address      = addr;
        d.address_bytes      = abytes;
        d.data_count         = cnt;
        d.needs_write_enable = we;
        d.wait_limit_ms      = ms;
        d.last               = 1'b1;
        return d;
    endfunction

    // A range error carries nothing but its status and the closing flag.
    function automatic t_desc fault(input t_status st);
        return reply(st, '0, '0, '0, '0, 1'b0, '0);
    endfunction

    function automatic t_row ask(input logic [2:0] kind, input logic [ADDR_W-1:0] tgt,
                                 input logic [COUNT_W-1:0] cnt);
        t_row r;
        r.is_cfg = 1'b0;
        r.blocks = '0;
        r.kind   = kind;
        r.target = tgt;
        r.count  = cnt;
        r.typed  = 1'b0;
        r.known  = '0;
        return r;
    endfunction

    function automatic t_row ask_known(input logic [2:0] kind, input logic [ADDR_W-1:0] tgt,
                                       input logic [COUNT_W-1:0] cnt, input t_desc answer);
        t_row r;
        r = ask(kind, tgt, cnt);
        r.typed = 1'b1;
        r.known = answer;
        return r;
    endfunction

    function automatic t_row set_blocks(input logic [CFG_W-1:0] value);
        t_row r;
        r = ask('0, '0, '0);
        r.is_cfg = 1'b1;
        r.blocks = value;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Descriptor planner: what the block must send for one accepted request
    // ---------------------------------------------------------------------------------
    function automatic void plan_descriptors(input logic [2:0] kind,
                                             input logic [ADDR_W-1:0] tgt,
                                             input logic [COUNT_W-1:0] cnt);
        t_desc d;
        logic wide;
        logic [ADDR_W-1:0] amask;
        logic [2:0] abytes;
        logic [63:0] chip_bytes;
        logic [63:0] scaled;
        logic [COUNT_W-1:0] n;
        logic [ADDR_W-1:0] room;
        logic [ADDR_W-1:0] len;
        int frames;
        bit stop;
        // Large chips switch every command to four-byte addressing; three-byte frames
        // carry only the low 24 address bits.
        wide       = flash_blocks >= WIDE_THRESHOLD;
        amask      = wide ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        abytes     = wide ? 3'd4 : 3'd3;
        chip_bytes = 64'(flash_blocks) * BLOCK_BYTES;
        // Over-long requests are cut down to the largest buffer.
        n = (cnt > MAX_REQUEST_BYTES) ? COUNT_W'(MAX_REQUEST_BYTES) : cnt;
        case (kind)
            REQ_READ: begin
                // Reads are never range-checked.
                planned_descs.push_back(reply(ST_OK, wide ? OPC_READ4 : OPC_READ3,
                                              tgt & amask, abytes, n, 1'b0, '0));
            end
            REQ_WRITE: begin
                // One frame per page touched. A zero-length write still sends one empty
                // frame. Running off the chip ends the request with a page error, after
                // any frames already sent.
                walk_addr  = tgt;
                walk_left  = n;
                walk_index = '0;
                frames     = 0;
                stop       = 1'b0;
                while (!stop) begin
                    if (64'(walk_addr / PAGE_BYTES) >= chip_bytes / PAGE_BYTES) begin
                        planned_descs.push_back(fault(ST_PAGE));
                        stop = 1'b1;
                    end else begin
                        room      = PAGE_BYTES - (walk_addr % PAGE_BYTES);
                        len       = (32'(walk_left) < room) ? 32'(walk_left) : room;
                        walk_left = walk_left - COUNT_W'(len);
                        frames++;
                        d = reply(ST_OK, wide ? OPC_WRITE4 : OPC_WRITE3, walk_addr & amask,
                                  abytes, COUNT_W'(len), 1'b1, WAIT_PAGE);
                        d.data_offset = walk_index;
                        d.last = (walk_left == 0) || (frames == RESULT_LIMIT);
                        planned_descs.push_back(d);
                        walk_addr  = walk_addr + len;
                        walk_index = walk_index + COUNT_W'(len);
                        stop = d.last;
                    end
                end
            end
            REQ_SECTOR: begin
                scaled = 64'(tgt) * SECTOR_BYTES;
                if (64'(tgt) >= chip_bytes / SECTOR_BYTES) begin
                    planned_descs.push_back(fault(ST_SECTOR));
                end else begin
                    planned_descs.push_back(reply(ST_OK, wide ? OPC_SECTOR4 : OPC_SECTOR3,
                                                  scaled[ADDR_W-1:0] & amask, abytes, '0,
                                                  1'b1, WAIT_SECTOR));
                end
            end
            REQ_BLOCK: begin
                scaled = 64'(tgt) * BLOCK_BYTES;
                if (tgt >= 32'(flash_blocks)) begin
                    planned_descs.push_back(fault(ST_BLOCK));
                end else begin
                    planned_descs.push_back(reply(ST_OK, wide ? OPC_BLOCK4 : OPC_BLOCK3,
                                                  scaled[ADDR_W-1:0] & amask, abytes, '0,
                                                  1'b1, WAIT_BLOCK));
                end
            end
            REQ_CHIP: begin
                // No address at all; the poll limit grows with the chip.
                planned_descs.push_back(reply(ST_OK, OPC_CHIP, '0, '0, '0, 1'b1,
                                              WAIT_W'(32'(flash_blocks) * WAIT_PER_BLOCK)));
            end
            default: begin
                // Unknown request codes are swallowed without a descriptor.
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Idling, driving and draining
    // ---------------------------------------------------------------------------------
    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Offers one request and returns at the clock edge that takes it. Nothing is
    // assigned after that edge, so the next call may keep valid high or drop it.
    task automatic send_request(input logic [2:0] kind, input logic [ADDR_W-1:0] tgt,
                                input logic [COUNT_W-1:0] cnt, input bit typed,
                                input t_desc known);
        int gap;
        if (idle_roll()) begin
            req_bus.valid <= 1'b0;
            gap = 0;
            do begin
                @(posedge i_clk);
                gap++;
            end while (gap < MAX_GAP && idle_roll());
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.target     <= tgt;
        req_bus.byte_count <= cnt;
        do @(posedge i_clk); while (!req_bus.ready);
        reqs_sent++;
        if (kind > REQ_CHIP)
            reqs_ignored++;
        if (typed)
            planned_descs.push_back(known);
        else
            plan_descriptors(kind, tgt, cnt);
    endtask

    // Stops offering requests, waits for every planned descriptor and then lets the
    // block finish any request that sends nothing back.
    task automatic drain_descriptors();
        req_bus.valid <= 1'b0;
        while (planned_descs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle. The block clamps the value at 1024.
    task automatic program_blocks(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        flash_blocks = (value > BLOCK_COUNT_MAX) ? BLOCK_COUNT_MAX : value;
        settings_written++;
    endtask

    // Random requests are mostly aimed inside the chip, with a fair share close to its
    // end (so writes run off it) and some far outside it.
    task automatic random_request(output bit counted);
        logic [2:0] kind;
        logic [ADDR_W-1:0] tgt;
        logic [COUNT_W-1:0] cnt;
        logic [ADDR_W-1:0] span;
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            kind = REQ_READ;
        else if (roll < 60)
            kind = REQ_WRITE;
        else if (roll < 75)
            kind = REQ_SECTOR;
        else if (roll < 87)
            kind = REQ_BLOCK;
        else if (roll < 92)
            kind = REQ_CHIP;
        else
            kind = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));

        case ($urandom_range(9))
            0: cnt = COUNT_W'($urandom_range(8191));
            1: cnt = COUNT_W'($urandom_range(MAX_REQUEST_BYTES, MAX_REQUEST_BYTES - 16));
            2: cnt = '0;
            default: cnt = COUNT_W'($urandom_range(300));
        endcase

        case (kind)
            REQ_READ, REQ_WRITE: span = 32'(flash_blocks) * BLOCK_BYTES;
            REQ_SECTOR:          span = 32'(flash_blocks) * (BLOCK_BYTES / SECTOR_BYTES);
            REQ_BLOCK:           span = 32'(flash_blocks);
            default:             span = '0;
        endcase

        case ($urandom_range(9))
            0: tgt = $urandom();
            1: tgt = span - 32'($urandom_range(8, 1));
            2: tgt = span + 32'($urandom_range(8));
            3: tgt = span - 32'($urandom_range(600, 9));
            default: tgt = (span == 0) ? $urandom() : 32'($urandom_range(span - 1));
        endcase

        send_request(kind, tgt, cnt, 1'b0, '0);
        counted = (kind <= REQ_CHIP);
    endtask

    // ---------------------------------------------------------------------------------
    // Descriptor side: random back-pressure and checking of every accepted descriptor
    // ---------------------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: descriptor %0d, %s expected %0h actual %0h",
                         $time, descs_checked, name, want, got);
        end
    endfunction

    function automatic void check_descriptor();
        t_desc want;
        if (planned_descs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: descriptor expected none, actual status %0d opcode %0h address %0h",
                         $time, desc_bus.status, desc_bus.opcode, desc_bus.flash_address);
        end else begin
            want = planned_descs.pop_front();
            if (want.status != ST_OK)
                range_errors++;
            compare_field("status", want.status, desc_bus.status);
            compare_field("opcode", want.opcode, desc_bus.opcode);
            compare_field("flash_address", want.flash_address, desc_bus.flash_address);
            compare_field("address_bytes", want.address_bytes, desc_bus.address_bytes);
            compare_field("data_offset", want.data_offset, desc_bus.data_offset);
            compare_field("data_count", want.data_count, desc_bus.data_count);
            compare_field("needs_write_enable", want.needs_write_enable,
                          desc_bus.needs_write_enable);
            compare_field("wait_limit_ms", want.wait_limit_ms, desc_bus.wait_limit_ms);
            compare_field("last", want.last, desc_bus.last);
        end
        descs_checked++;
    endfunction

    initial begin
        int stall;
        stall = 0;
        desc_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (desc_bus.valid && desc_bus.ready)
                check_descriptor();
            // Stalls are kept short so that the watchdog never trips on a correct run.
            if (stall < MAX_STALL && idle_roll()) begin
                desc_bus.ready <= 1'b0;
                stall++;
            end else begin
                desc_bus.ready <= 1'b1;
                stall = 0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel moves an item
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (desc_bus.valid && desc_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Main sequence: reset, directed part, random phases, final report
    // ---------------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] phase_setting [PHASES];
        int done;
        bit counted;
        bit paused;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_READ;
        req_bus.target     = '0;
        req_bus.byte_count = '0;

        // The directed part starts on an empty chip (block_count is cleared by reset),
        // then covers the largest register value, both sides of the addressing switch
        // and a one-block chip. Together the lines hit the field extremes, the length
        // clamp, every known request code, two unknown ones, the empty write, writes that
        // run off the chip and a 4 KiB write that needs the full seventeen frames.
        directed_plan = '{
            ask_known(REQ_READ, 32'hFFFF_FFFF, 13'h1FFF,
                      reply(ST_OK, OPC_READ3, 32'h00FF_FFFF, 3'd3, 13'd4096, 1'b0, '0)),
            ask_known(REQ_WRITE, 32'h0, 13'd1, fault(ST_PAGE)),
            ask_known(REQ_SECTOR, 32'h0, 13'd0, fault(ST_SECTOR)),
            ask_known(REQ_BLOCK, 32'h0, 13'd0, fault(ST_BLOCK)),
            ask_known(REQ_CHIP, 32'h0, 13'd0, reply(ST_OK, OPC_CHIP, '0, '0, '0, 1'b1, '0)),
            set_blocks(11'h7FF),
            ask_known(REQ_READ, 32'hFFFF_FFFF, 13'd0,
                      reply(ST_OK, OPC_READ4, 32'hFFFF_FFFF, 3'd4, '0, 1'b0, '0)),
            ask(REQ_WRITE, 32'h03FF_FF80, 13'd4096),
            ask(REQ_WRITE, 32'h0000_0010, 13'd4096),
            ask(REQ_WRITE, 32'h0000_0100, 13'd0),
            ask(REQ_WRITE, 32'h03FF_FF00, 13'd256),
            ask_known(REQ_SECTOR, 32'd16383, 13'd0,
                      reply(ST_OK, OPC_SECTOR4, 32'h03FF_F000, 3'd4, '0, 1'b1, WAIT_SECTOR)),
            ask_known(REQ_SECTOR, 32'd16384, 13'd0, fault(ST_SECTOR)),
            ask_known(REQ_BLOCK, 32'd1023, 13'd0,
                      reply(ST_OK, OPC_BLOCK4, 32'h03FF_0000, 3'd4, '0, 1'b1, WAIT_BLOCK)),
            ask_known(REQ_BLOCK, 32'd1024, 13'd0, fault(ST_BLOCK)),
            ask_known(REQ_CHIP, 32'h0, 13'd0,
                      reply(ST_OK, OPC_CHIP, '0, '0, '0, 1'b1, 20'd1024000)),
            ask(REQ_SPARE_LO, 32'hA5A5_A5A5, 13'd100),
            ask(REQ_SPARE_HI, 32'h5A5A_5A5A, 13'h1FFF),
            set_blocks(11'd511),
            ask(REQ_WRITE, 32'h01FE_FFF0, 13'd64),
            ask(REQ_SECTOR, 32'd8175, 13'd0),
            ask(REQ_BLOCK, 32'd510, 13'd0),
            ask(REQ_READ, 32'h0123_4567, 13'd4096),
            set_blocks(11'd512),
            ask(REQ_BLOCK, 32'd511, 13'd0),
            ask(REQ_SECTOR, 32'd8191, 13'd0),
            ask(REQ_WRITE, 32'h01FF_FF00, 13'd300),
            set_blocks(11'd1),
            ask(REQ_BLOCK, 32'd1, 13'd0),
            ask(REQ_SECTOR, 32'd15, 13'd0),
            ask(REQ_WRITE, 32'h0000_FFF0, 13'd32)
        };

        // The random phases walk through the register's extremes, the addressing
        // switch and two random sizes.
        phase_setting[0] = 11'd1024;
        phase_setting[1] = 11'd0;
        phase_setting[2] = 11'd511;
        phase_setting[3] = 11'd512;
        phase_setting[4] = 11'h7FF;
        phase_setting[5] = 11'd1;
        phase_setting[6] = CFG_W'($urandom_range(1024, 1));
        phase_setting[7] = CFG_W'($urandom_range(2047));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                drain_descriptors();
                program_blocks(directed_plan[i].blocks);
            end else begin
                send_request(directed_plan[i].kind, directed_plan[i].target,
                             directed_plan[i].count, directed_plan[i].typed,
                             directed_plan[i].known);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_descriptors();
            program_blocks(phase_setting[phase]);
            calm   = (phase == CALM_PHASE);
            done   = 0;
            paused = 1'b0;
            while (done < ITEMS_PER_PHASE) begin
                if (phase == PRESSURE_PHASE && !paused && done == ITEMS_PER_PHASE / 2) begin
                    drain_descriptors();
                    paused = 1'b1;
                end
                random_request(counted);
                if (counted)
                    done++;
            end
        end

        calm = 1'b0;
        drain_descriptors();

        $display("Sent %0d requests (%0d with unknown codes) across %0d block_count settings.",
                 reqs_sent, reqs_ignored, settings_written);
        $display("Checked %0d descriptors, %0d of them range errors, with %0d mismatches.",
                 descs_checked, range_errors, mismatches);
        if (mismatches == 0 && planned_descs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sfcp_pkg.sv
sv/sfcp_req_if.sv
sv/sfcp_desc_if.sv
sv/sfcp_dpath.sv
sv/serial_flash_command_planner.sv
verif/testbench.sv
